// ===== rtl/core/bgeb_pkg.sv =====
// Package for the binary grid erosion and bounding box unit.
// Holds line and coordinate widths, register indexes, transaction structs and the erosion function.
// Depends on nothing; every other file of the unit uses it.
`default_nettype none

package bgeb_pkg;

   localparam int LINE_W   = 32;
   localparam int ROW_W    = 10;
   localparam int COL_W    = 5;
   localparam int COLS_W   = 6;
   localparam int ROWS_W   = 11;
   localparam int CSR_W    = 11;
   localparam int SEA_LIMIT = 3;

   localparam logic [ROWS_W-1:0] MAX_ROWS = 11'd1024;
   localparam logic [COLS_W-1:0] MAX_COLS = 6'd32;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_BOX   = 1'b1;

   typedef enum logic [1:0] {
      PHASE_HEAD,
      PHASE_FLUSH,
      PHASE_BOX
   } back_phase_type;

   typedef struct packed {
      logic              has_pixel;
      logic [ROW_W-1:0]  pix_row;
      logic [COL_W-1:0]  pix_col;
      logic              pix_land;
      logic              has_flush;
      logic [LINE_W-1:0] flush_up;
      logic [LINE_W-1:0] flush_mid;
      logic [ROW_W-1:0]  flush_row;
      logic [COLS_W-1:0] flush_cols;
   } cmd_type;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic             land_after;
      logic [ROW_W-1:0] box_top;
      logic [ROW_W-1:0] box_bottom;
      logic [COL_W-1:0] box_left;
      logic [COL_W-1:0] box_right;
      logic             box_empty;
      logic             last;
   } rsp_type;

   // A land pixel turns to sea when enough of its four neighbors are sea.
   function automatic logic erode(input logic [LINE_W-1:0] up,
                                  input logic [LINE_W-1:0] mid,
                                  input logic [LINE_W-1:0] down,
                                  input logic [COL_W-1:0]  col,
                                  input logic [COLS_W-1:0] cols);
      logic [2:0] sea;
      logic       left_sea;
      logic       right_sea;
      sea       = 3'd0;
      left_sea  = (col == '0) || !mid[col - COL_W'(1)];
      right_sea = (({1'b0, col} + COLS_W'(1)) >= cols) || !mid[col + COL_W'(1)];
      sea = 3'(!up[col]) + 3'(!down[col]) + 3'(left_sea) + 3'(right_sea);
      return mid[col] && (sea < 3'(SEA_LIMIT));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/binary_grid_erosion_bbox_unit.sv =====
// Top level of the binary grid erosion and bounding box unit.
// Holds the size registers and connects bgeb_front, bgeb_queue and bgeb_back; uses bgeb_pkg.
//
// Pixels of a land/sea grid enter in raster order, one transaction per clock while full is
// low, and the eroded pixel one row above leaves through the command queue and a registered
// result stage. The front end keeps three line buffers and erodes that pixel at once; a command
// queue of QUEUE_DEPTH entries separates it from the back end, which delivers one result per
// clock while results are taken. On the frame's last pixel the back end also emits the whole
// final row, one pixel per clock while results are taken, and then the bounding box result,
// so that last pixel yields the column count in use plus two results (plus one when the frame
// has a single row). The input reports full whenever the command queue is full, which happens
// when results are not taken or when frame ends follow each other faster than their final rows
// drain. The size registers must be written while the unit is idle.
`default_nettype none

module binary_grid_erosion_bbox_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output      logic                        full,
   input  wire logic                        req_land,
   output      logic                        empty,
   input  wire logic                        pop,
   output      logic                        rsp_kind,
   output      logic [bgeb_pkg::ROW_W-1:0]  rsp_pixel_row,
   output      logic [bgeb_pkg::COL_W-1:0]  rsp_pixel_col,
   output      logic                        rsp_land_after,
   output      logic [bgeb_pkg::ROW_W-1:0]  rsp_box_top,
   output      logic [bgeb_pkg::ROW_W-1:0]  rsp_box_bottom,
   output      logic [bgeb_pkg::COL_W-1:0]  rsp_box_left,
   output      logic [bgeb_pkg::COL_W-1:0]  rsp_box_right,
   output      logic                        rsp_box_empty,
   output      logic                        rsp_last,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [bgeb_pkg::CSR_W-1:0]  csr_wr_data
);

   logic [bgeb_pkg::ROWS_W-1:0] row_count_ff, row_count_in;
   logic [bgeb_pkg::COLS_W-1:0] col_count_ff, col_count_in;

   logic              accept;
   logic              cmd_push;
   bgeb_pkg::cmd_type cmd;
   logic              q_full;
   logic              cmd_pop;
   logic              head_valid;
   bgeb_pkg::cmd_type head_cmd;
   logic              rsp_valid;
   bgeb_pkg::rsp_type rsp;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bgeb_pkg::CSR_ROW_COUNT: row_count_in = csr_wr_data;
            bgeb_pkg::CSR_COL_COUNT: col_count_in = csr_wr_data[bgeb_pkg::COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= bgeb_pkg::ROWS_W'(10);
         col_count_ff <= bgeb_pkg::COLS_W'(10);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   assign full   = q_full;
   assign accept = req_push && !q_full;

   bgeb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .land      (req_land),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   bgeb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (q_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   bgeb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign empty          = !rsp_valid;
   assign rsp_kind       = rsp.kind;
   assign rsp_pixel_row  = rsp.pixel_row;
   assign rsp_pixel_col  = rsp.pixel_col;
   assign rsp_land_after = rsp.land_after;
   assign rsp_box_top    = rsp.box_top;
   assign rsp_box_bottom = rsp.box_bottom;
   assign rsp_box_left   = rsp.box_left;
   assign rsp_box_right  = rsp.box_right;
   assign rsp_box_empty  = rsp.box_empty;
   assign rsp_last       = rsp.last;

   // The queue never takes a command while it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command pushed into a full queue");

   // The back end never pops a command that is not there.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> head_valid)
      else $error("command popped from an empty queue");

   // A box transaction always closes the results of its input.
   a_box_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind) |-> rsp_last)
      else $error("box transaction without last");

   // An empty box carries zero coordinates.
   a_empty_box_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_box_empty) |-> (rsp_box_top == '0 && rsp_box_bottom == '0 &&
                                     rsp_box_left == '0 && rsp_box_right == '0))
      else $error("empty box with nonzero coordinates");

endmodule

`default_nettype wire

// ===== rtl/core/bgeb_front.sv =====
// Front end: accepts pixels, keeps the three line buffers and raster position.
// Erodes the pixel one row back and issues commands for the back end. Uses bgeb_pkg.
`default_nettype none

module bgeb_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         land,
   input  wire logic [bgeb_pkg::ROWS_W-1:0]  row_count,
   input  wire logic [bgeb_pkg::COLS_W-1:0]  col_count,
   output      logic                         cmd_push,
   output      bgeb_pkg::cmd_type            cmd
);

   logic [bgeb_pkg::LINE_W-1:0] two_back_ff, two_back_in;
   logic [bgeb_pkg::LINE_W-1:0] one_back_ff, one_back_in;
   logic [bgeb_pkg::LINE_W-1:0] filling_ff, filling_in;
   logic [bgeb_pkg::ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [bgeb_pkg::COL_W-1:0]  col_pos_ff, col_pos_in;

   logic [bgeb_pkg::ROWS_W-1:0] rows;
   logic [bgeb_pkg::COLS_W-1:0] cols;
   logic [bgeb_pkg::COL_W-1:0]  col;
   logic [bgeb_pkg::LINE_W-1:0] filling_new;
   logic                        row_end;
   logic                        frame_end;

   always_comb begin
      if (row_count == '0) begin
         rows = bgeb_pkg::ROWS_W'(1);
      end else if (row_count > bgeb_pkg::MAX_ROWS) begin
         rows = bgeb_pkg::MAX_ROWS;
      end else begin
         rows = row_count;
      end
      if (col_count == '0) begin
         cols = bgeb_pkg::COLS_W'(1);
      end else if (col_count > bgeb_pkg::MAX_COLS) begin
         cols = bgeb_pkg::MAX_COLS;
      end else begin
         cols = col_count;
      end
      if ({1'b0, col_pos_ff} >= cols) begin
         col = bgeb_pkg::COL_W'(cols - bgeb_pkg::COLS_W'(1));
      end else begin
         col = col_pos_ff;
      end
      filling_new      = filling_ff;
      filling_new[col] = land;
      row_end   = ({1'b0, col} + bgeb_pkg::COLS_W'(1)) >= cols;
      frame_end = row_end && (({1'b0, row_pos_ff} + bgeb_pkg::ROWS_W'(1)) >= rows);

      cmd.has_pixel  = row_pos_ff != '0;
      cmd.pix_row    = row_pos_ff - bgeb_pkg::ROW_W'(1);
      cmd.pix_col    = col;
      cmd.pix_land   = bgeb_pkg::erode(two_back_ff, one_back_ff, filling_new, col, cols);
      cmd.has_flush  = frame_end;
      cmd.flush_up   = one_back_ff;
      cmd.flush_mid  = filling_new;
      cmd.flush_row  = row_pos_ff;
      cmd.flush_cols = cols;
      cmd_push = accept && (cmd.has_pixel || cmd.has_flush);

      two_back_in = two_back_ff;
      one_back_in = one_back_ff;
      filling_in  = filling_ff;
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      if (accept) begin
         priority if (frame_end) begin
            two_back_in = '0;
            one_back_in = '0;
            filling_in  = '0;
            row_pos_in  = '0;
            col_pos_in  = '0;
         end else if (row_end) begin
            two_back_in = one_back_ff;
            one_back_in = filling_new;
            filling_in  = '0;
            row_pos_in  = row_pos_ff + bgeb_pkg::ROW_W'(1);
            col_pos_in  = '0;
         end else begin
            filling_in  = filling_new;
            col_pos_in  = col + bgeb_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         two_back_ff <= '0;
         one_back_ff <= '0;
         filling_ff  <= '0;
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
      end else begin
         two_back_ff <= two_back_in;
         one_back_ff <= one_back_in;
         filling_ff  <= filling_in;
         row_pos_ff  <= row_pos_in;
         col_pos_ff  <= col_pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bgeb_queue.sv =====
// Command queue between the front end and the back end.
// A small register FIFO of bgeb_pkg::cmd_type entries; uses bgeb_pkg.
`default_nettype none

module bgeb_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bgeb_pkg::cmd_type push_cmd,
   output      logic              full,
   input  wire logic              pop,
   output      logic              head_valid,
   output      bgeb_pkg::cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bgeb_pkg::cmd_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      full       = count_ff == CNT_W'(DEPTH);
      head_valid = count_ff != '0;
      head_cmd   = slot_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bgeb_back.sv =====
// Back end: turns commands into results, flushes the final row and tracks the bounding box.
// Drives the registered result stage. Uses bgeb_pkg.
`default_nettype none

module bgeb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire bgeb_pkg::cmd_type head_cmd,
   output      logic              cmd_pop,
   input  wire logic              rsp_pop,
   output      logic              rsp_valid,
   output      bgeb_pkg::rsp_type rsp
);

   bgeb_pkg::back_phase_type    phase_ff, phase_in;
   logic [bgeb_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bgeb_pkg::ROW_W-1:0]  top_ff, top_in;
   logic [bgeb_pkg::ROW_W-1:0]  bottom_ff, bottom_in;
   logic [bgeb_pkg::COL_W-1:0]  left_ff, left_in;
   logic [bgeb_pkg::COL_W-1:0]  right_ff, right_in;
   logic                        any_ff, any_in;
   logic                        valid_ff, valid_in;
   bgeb_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        slot_ready;
   logic                        produce;
   bgeb_pkg::rsp_type           res;
   logic                        flush_land;

   always_comb begin
      slot_ready = !valid_ff || rsp_pop;
      flush_land = bgeb_pkg::erode(head_cmd.flush_up, head_cmd.flush_mid, '0, col_ff,
                                   head_cmd.flush_cols);
      produce  = 1'b0;
      res      = '0;
      cmd_pop  = 1'b0;
      phase_in = phase_ff;
      col_in   = col_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      any_in    = any_ff;

      unique case (phase_ff)
         bgeb_pkg::PHASE_HEAD: begin
            if (head_valid && slot_ready) begin
               if (head_cmd.has_pixel) begin
                  produce        = 1'b1;
                  res.kind       = bgeb_pkg::KIND_PIXEL;
                  res.pixel_row  = head_cmd.pix_row;
                  res.pixel_col  = head_cmd.pix_col;
                  res.land_after = head_cmd.pix_land;
                  res.last       = !head_cmd.has_flush;
               end
               if (head_cmd.has_flush) begin
                  phase_in = bgeb_pkg::PHASE_FLUSH;
                  col_in   = '0;
               end else begin
                  cmd_pop = 1'b1;
               end
            end
         end
         bgeb_pkg::PHASE_FLUSH: begin
            if (slot_ready) begin
               produce        = 1'b1;
               res.kind       = bgeb_pkg::KIND_PIXEL;
               res.pixel_row  = head_cmd.flush_row;
               res.pixel_col  = col_ff;
               res.land_after = flush_land;
               if (({1'b0, col_ff} + bgeb_pkg::COLS_W'(1)) >= head_cmd.flush_cols) begin
                  phase_in = bgeb_pkg::PHASE_BOX;
               end else begin
                  col_in = col_ff + bgeb_pkg::COL_W'(1);
               end
            end
         end
         bgeb_pkg::PHASE_BOX: begin
            if (slot_ready) begin
               produce   = 1'b1;
               res.kind  = bgeb_pkg::KIND_BOX;
               res.last  = 1'b1;
               if (any_ff) begin
                  res.box_top    = top_ff;
                  res.box_bottom = bottom_ff;
                  res.box_left   = left_ff;
                  res.box_right  = right_ff;
               end else begin
                  res.box_empty  = 1'b1;
               end
               cmd_pop  = 1'b1;
               phase_in = bgeb_pkg::PHASE_HEAD;
            end
         end
         default: begin
            phase_in = bgeb_pkg::PHASE_HEAD;
         end
      endcase

      if (produce && (res.kind == bgeb_pkg::KIND_PIXEL) && res.land_after) begin
         if (!any_ff || (res.pixel_row < top_ff)) top_in = res.pixel_row;
         if (!any_ff || (res.pixel_row > bottom_ff)) bottom_in = res.pixel_row;
         if (!any_ff || (res.pixel_col < left_ff)) left_in = res.pixel_col;
         if (!any_ff || (res.pixel_col > right_ff)) right_in = res.pixel_col;
         any_in = 1'b1;
      end
      if (produce && (res.kind == bgeb_pkg::KIND_BOX)) begin
         top_in    = '1;
         bottom_in = '0;
         left_in   = '1;
         right_in  = '0;
         any_in    = 1'b0;
      end

      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (produce) begin
         valid_in = 1'b1;
         rsp_in   = res;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end

      rsp_valid = valid_ff;
      rsp       = rsp_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bgeb_pkg::PHASE_HEAD;
         col_ff    <= '0;
         top_ff    <= '1;
         bottom_ff <= '0;
         left_ff   <= '1;
         right_ff  <= '0;
         any_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         any_ff    <= any_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/binary_grid_erosion_bbox_unit_test.sv =====
// Self-checking testbench for binary_grid_erosion_bbox_unit: directed and random land/sea
// frames, eroded pixels and bounding boxes checked against an in-bench predictor held in a
// scoreboard class. Depends on bgeb_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module binary_grid_erosion_bbox_unit_test;

   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PAD_W         = bgeb_pkg::CSR_W - bgeb_pkg::COLS_W;

   class erosion_scoreboard;
      logic [bgeb_pkg::ROWS_W-1:0] row_setting;
      logic [bgeb_pkg::COLS_W-1:0] col_setting;
      logic [bgeb_pkg::LINE_W-1:0] two_up;
      logic [bgeb_pkg::LINE_W-1:0] one_up;
      logic [bgeb_pkg::LINE_W-1:0] current_line;
      int                          row_at;
      int                          col_at;
      int                          top_row;
      int                          bottom_row;
      int                          left_col;
      int                          right_col;
      bit                          land_seen;
      bgeb_pkg::rsp_type           expected_q[$];
      bgeb_pkg::rsp_type           held;
      bit                          holding;
      int                          errors;

      function new();
         row_setting = bgeb_pkg::ROWS_W'(10);
         col_setting = bgeb_pkg::COLS_W'(10);
         errors      = 0;
         holding     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         two_up       = '0;
         one_up       = '0;
         current_line = '0;
         row_at       = 0;
         col_at       = 0;
         top_row      = 0;
         bottom_row   = 0;
         left_col     = 0;
         right_col    = 0;
         land_seen    = 0;
      endfunction

      function void set_reg(input logic idx, input logic [bgeb_pkg::CSR_W-1:0] data);
         if (idx == bgeb_pkg::CSR_ROW_COUNT) row_setting = data[bgeb_pkg::ROWS_W-1:0];
         else col_setting = data[bgeb_pkg::COLS_W-1:0];
      endfunction

      function int rows_in_use();
         if (row_setting == 0) return 1;
         if (row_setting > bgeb_pkg::MAX_ROWS) return int'(bgeb_pkg::MAX_ROWS);
         return int'(row_setting);
      endfunction

      function int cols_in_use();
         if (col_setting == 0) return 1;
         if (col_setting > bgeb_pkg::MAX_COLS) return int'(bgeb_pkg::MAX_COLS);
         return int'(col_setting);
      endfunction

      function int waiting();
         return expected_q.size();
      endfunction

      // The newest result is held back so that it can be flagged as the last one.
      function void queue_result(input bgeb_pkg::rsp_type res);
         if (holding) expected_q.insert(expected_q.size(), held);
         held    = res;
         holding = 1;
      endfunction

      function void erode_pixel(input logic [bgeb_pkg::LINE_W-1:0] up,
                                input logic [bgeb_pkg::LINE_W-1:0] mid,
                                input logic [bgeb_pkg::LINE_W-1:0] down, input int r,
                                input int c, input int cols);
         int                sea_sides;
         bit                stays;
         bgeb_pkg::rsp_type res;
         sea_sides = 0;
         if (!up[c]) sea_sides++;
         if (!down[c]) sea_sides++;
         if (c == 0 || !mid[c-1]) sea_sides++;
         if (c + 1 >= cols || !mid[c+1]) sea_sides++;
         stays = mid[c] && (sea_sides < bgeb_pkg::SEA_LIMIT);
         if (stays) begin
            if (!land_seen || r < top_row) top_row = r;
            if (!land_seen || r > bottom_row) bottom_row = r;
            if (!land_seen || c < left_col) left_col = c;
            if (!land_seen || c > right_col) right_col = c;
            land_seen = 1;
         end
         res            = '0;
         res.kind       = bgeb_pkg::KIND_PIXEL;
         res.pixel_row  = r[bgeb_pkg::ROW_W-1:0];
         res.pixel_col  = c[bgeb_pkg::COL_W-1:0];
         res.land_after = stays;
         queue_result(res);
      endfunction

      function void note_pixel(input bit land);
         int                cols;
         int                rows;
         int                c;
         int                r;
         int                j;
         bit                row_end;
         bit                frame_end;
         bgeb_pkg::rsp_type box;
         cols = cols_in_use();
         rows = rows_in_use();
         c    = col_at;
         r    = row_at;
         if (c >= cols) c = cols - 1;
         current_line[c] = land;
         holding = 0;
         if (r >= 1) erode_pixel(two_up, one_up, current_line, r - 1, c, cols);
         row_end   = (c + 1 >= cols);
         frame_end = row_end && (r + 1 >= rows);
         if (frame_end) begin
            for (j = 0; j < cols; j++) erode_pixel(one_up, current_line, '0, r, j, cols);
            box      = '0;
            box.kind = bgeb_pkg::KIND_BOX;
            if (land_seen) begin
               box.box_top    = top_row[bgeb_pkg::ROW_W-1:0];
               box.box_bottom = bottom_row[bgeb_pkg::ROW_W-1:0];
               box.box_left   = left_col[bgeb_pkg::COL_W-1:0];
               box.box_right  = right_col[bgeb_pkg::COL_W-1:0];
            end else begin
               box.box_empty = 1'b1;
            end
            queue_result(box);
            clear_frame();
         end else if (row_end) begin
            two_up       = one_up;
            one_up       = current_line;
            current_line = '0;
            col_at       = 0;
            row_at       = r + 1;
         end else begin
            col_at = c + 1;
         end
         if (holding) begin
            held.last = 1'b1;
            expected_q.insert(expected_q.size(), held);
            holding = 0;
         end
      endfunction

      function string describe(input bgeb_pkg::rsp_type r);
         return $sformatf({"kind %0d pixel (%0d,%0d) land %0d box rows %0d-%0d ",
                           "cols %0d-%0d empty %0d last %0d"},
                          r.kind, r.pixel_row, r.pixel_col, r.land_after, r.box_top,
                          r.box_bottom, r.box_left, r.box_right, r.box_empty, r.last);
      endfunction

      function void check_result(input bgeb_pkg::rsp_type got);
         bgeb_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction: %s", describe(got));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.pixel_row !== want.pixel_row ||
             got.pixel_col !== want.pixel_col || got.land_after !== want.land_after ||
             got.box_top !== want.box_top || got.box_bottom !== want.box_bottom ||
             got.box_left !== want.box_left || got.box_right !== want.box_right ||
             got.box_empty !== want.box_empty || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("result differs, expected: %s", describe(want));
               $display("                  actual: %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_push    = 1'b0;
   logic                          req_land    = 1'b0;
   logic                          pop         = 1'b0;
   logic                          csr_wr_en   = 1'b0;
   logic                          csr_index   = bgeb_pkg::CSR_ROW_COUNT;
   logic [bgeb_pkg::CSR_W-1:0]    csr_wr_data = '0;
   logic                          full;
   logic                          empty;
   logic                          rsp_kind;
   logic [bgeb_pkg::ROW_W-1:0]    rsp_pixel_row;
   logic [bgeb_pkg::COL_W-1:0]    rsp_pixel_col;
   logic                          rsp_land_after;
   logic [bgeb_pkg::ROW_W-1:0]    rsp_box_top;
   logic [bgeb_pkg::ROW_W-1:0]    rsp_box_bottom;
   logic [bgeb_pkg::COL_W-1:0]    rsp_box_left;
   logic [bgeb_pkg::COL_W-1:0]    rsp_box_right;
   logic                          rsp_box_empty;
   logic                          rsp_last;

   erosion_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pixels_sent    = 0;

   binary_grid_erosion_bbox_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .full           (full),
      .req_land       (req_land),
      .empty          (empty),
      .pop            (pop),
      .rsp_kind       (rsp_kind),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_land_after (rsp_land_after),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_bottom (rsp_box_bottom),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_right  (rsp_box_right),
      .rsp_box_empty  (rsp_box_empty),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin : take_result
      bgeb_pkg::rsp_type got;
      if (!reset && pop && !empty) begin
         got.kind       = rsp_kind;
         got.pixel_row  = rsp_pixel_row;
         got.pixel_col  = rsp_pixel_col;
         got.land_after = rsp_land_after;
         got.box_top    = rsp_box_top;
         got.box_bottom = rsp_box_bottom;
         got.box_left   = rsp_box_left;
         got.box_right  = rsp_box_right;
         got.box_empty  = rsp_box_empty;
         got.last       = rsp_last;
         sb.check_result(got);
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("binary_grid_erosion_bbox_unit: mismatch");
      $finish;
   end

   task automatic push_pixel(input bit land);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_land <= land;
      do @(posedge clock); while (full);
      sb.note_pixel(land);
      pixels_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [bgeb_pkg::CSR_W-1:0] rows,
                              input logic [bgeb_pkg::CSR_W-1:0] cols);
      csr_wr_en   <= 1'b1;
      csr_index   <= bgeb_pkg::CSR_ROW_COUNT;
      csr_wr_data <= rows;
      @(posedge clock);
      sb.set_reg(bgeb_pkg::CSR_ROW_COUNT, rows);
      csr_index   <= bgeb_pkg::CSR_COL_COUNT;
      csr_wr_data <= cols;
      @(posedge clock);
      sb.set_reg(bgeb_pkg::CSR_COL_COUNT, cols);
      csr_wr_en <= 1'b0;
   endtask

   // Rows above first_land_row are all sea; one frame may pause until all results are in.
   task automatic push_frame(input int land_pct, input int first_land_row, input bit pause_once);
      int total;
      int cols;
      int pause_at;
      int i;
      cols     = sb.cols_in_use();
      total    = sb.rows_in_use() * cols;
      pause_at = pause_once ? $urandom_range(total - 1) : -1;
      for (i = 0; i < total; i++) begin
         if (i == pause_at) drain();
         push_pixel((i / cols) >= first_land_row && $urandom_range(99) < land_pct);
      end
   endtask

   initial begin : stimulus
      int               send_pcts [4];
      int               recv_pcts [4];
      int               phase;
      int               phase_goal;
      int               sel;
      int               rows_raw;
      int               cols_raw;
      bit               first;
      logic [PAD_W-1:0] pad;
      send_pcts = '{0, 71, 0, 20};
      recv_pcts = '{0, 0, 71, 20};
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_frame(60, 0, 0);
      drain();
      write_sizes(11'd1, 11'd1);
      push_pixel(1'b1);
      drain();
      write_sizes(11'd0, 11'd0);
      push_pixel(1'b1);
      drain();
      write_sizes(11'd3, 11'd3);
      push_frame(100, 0, 0);
      drain();
      write_sizes(11'd1, 11'd3);
      push_frame(100, 0, 0);
      drain();
      write_sizes(11'd2, 11'd4);
      repeat (6) push_pixel(1'b1);
      drain();
      write_sizes(11'd2, 11'd2);
      push_pixel(1'b1);
      drain();

      write_sizes(11'd2047, {5'd21, 6'd2});
      repeat (4) push_pixel(1'b1);
      drain();
      write_sizes(11'd1, 11'd2);
      repeat (2) push_pixel(1'b1);
      drain();
      write_sizes(11'd1, 11'd32);
      push_frame(75, 0, 0);

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = recv_pcts[phase];
         phase_goal     = pixels_sent + 10;
         first          = 1;
         while (pixels_sent < phase_goal) begin
            if (first || $urandom_range(99) < 70) begin
               drain();
               sel = $urandom_range(9);
               if (sel == 0) begin
                  rows_raw = $urandom_range(1);
                  cols_raw = $urandom_range(63);
               end else if (sel == 1) begin
                  rows_raw = $urandom_range(1, 3);
                  cols_raw = $urandom_range(32, 63);
               end else begin
                  rows_raw = $urandom_range(1, 8);
                  cols_raw = $urandom_range(1, 12);
               end
               pad = PAD_W'($urandom_range(31));
               write_sizes(rows_raw[bgeb_pkg::CSR_W-1:0],
                           {pad, cols_raw[bgeb_pkg::COLS_W-1:0]});
            end
            push_frame($urandom_range(40, 95), 0, first);
            first = 0;
         end
      end

      drain();
      if (sb.errors == 0 && sb.waiting() == 0)
         $display("binary_grid_erosion_bbox_unit: match");
      else
         $display("binary_grid_erosion_bbox_unit: mismatch");
      $finish;
   end

endmodule
